// ----- rtl/core/teq_pkg.sv -----
// Package for the timed event queue: sizes, operation and result codes,
// and the result word type. No dependencies.
package teq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_W = $clog2(MAX_RESULTS + 1);
  localparam int ENT_W = 48;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_ADVANCE = 3'd2;
  localparam logic [2:0] OP_LIST_AT = 3'd3;
  localparam logic [2:0] OP_LIST    = 3'd4;

  localparam logic [2:0] K_ADDED   = 3'd0;
  localparam logic [2:0] K_PAST    = 3'd1;
  localparam logic [2:0] K_FULL    = 3'd2;
  localparam logic [2:0] K_FIRED   = 3'd3;
  localparam logic [2:0] K_LISTED  = 3'd4;
  localparam logic [2:0] K_NONE    = 3'd5;
  localparam logic [2:0] K_REMOVED = 3'd6;

  typedef struct packed {
    logic [4:0]  cnt;
    logic [15:0] tag;
    logic [31:0] tm;
    logic [2:0]  kind;
  } res_t;

endpackage

// ----- rtl/core/teq_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read of the entry being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/timed_event_queue.sv -----
// Timed event queue top level: sequencer around one entry RAM.
// Depends on teq_pkg and teq_ram.

// The queue holds up to QUEUE_DEPTH events sorted by time in one RAM, read
// and rewritten one entry at a time by a sequencer. An add walks from the
// tail toward its slot, shifting later entries up. Remove and advance
// operations scan the stored entries from the head, compacting them in
// place; list operations scan them from the head without writing. A scan
// waits while the result side stalls. Rejected adds and unknown operations
// go straight to their final result. A new word is taken only once the
// previous operation has handed its last result to the output register.
module timed_event_queue
  import teq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // time_value[31:0], event_id[47:32]
  input  logic [2:0]  in_tuser,   // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // event_time[31:0], event_tag[47:32],
                                  // removed_count[52:48]
  output logic [2:0]  out_tuser,  // kind[2:0]
  output logic        out_tlast
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCRD  = 3'd1;
  localparam logic [2:0] S_SCPR  = 3'd2;
  localparam logic [2:0] S_ADRD  = 3'd3;
  localparam logic [2:0] S_ADCK  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [31:0]      tv_r, tv_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [31:0]      cur_r, cur_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [OCC_W-1:0] i_r, i_nxt;
  logic [OCC_W-1:0] j_r, j_nxt;
  logic [NUM_W-1:0] n_r, n_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             pre_r, pre_nxt;
  res_t             hold_r, hold_nxt;
  logic             hold_v_r, hold_v_nxt;
  res_t             out_r, out_nxt;
  logic             out_v_r, out_v_nxt;
  logic             last_r, last_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [ENT_W-1:0] wdata, rdata;
  logic [31:0]      rd_tm;
  logic             out_free, emit, drop, wr_op, list_op;
  logic [OCC_W-1:0] i_dec;

  assign rd_tm    = rdata[31:0];
  assign out_free = !out_v_r || out_tready;
  assign wr_op    = (op_r == OP_REMOVE) || (op_r == OP_ADVANCE);
  assign list_op  = (op_r == OP_LIST_AT) || (op_r == OP_LIST);
  assign i_dec    = i_r - OCC_W'(1);
  assign raddr    = (state_r == S_ADRD || state_r == S_ADCK) ? i_dec[IDX_W-1:0]
                                                              : i_r[IDX_W-1:0];

  teq_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Per-entry decision of the head scan.
  always_comb begin
    emit = 1'b0;
    drop = 1'b0;
    case (op_r)
      OP_REMOVE:  drop = (rd_tm == tv_r);
      OP_ADVANCE: begin
        drop = pre_r && (rd_tm <= cur_r) && (n_r < NUM_W'(MAX_RESULTS));
        emit = drop;
      end
      OP_LIST_AT: emit = (rd_tm == tv_r);
      OP_LIST:    emit = 1'b1;
      default:    ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    tv_nxt     = tv_r;
    id_nxt     = id_r;
    cur_nxt    = cur_r;
    occ_nxt    = occ_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    pre_nxt    = pre_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && !out_tready;
    last_nxt   = last_r;
    we         = 1'b0;
    waddr      = i_r[IDX_W-1:0];
    wdata      = {id_r, tv_r};
    in_tready  = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tuser;
          tv_nxt     = in_tdata[31:0];
          id_nxt     = in_tdata[47:32];
          i_nxt      = '0;
          j_nxt      = '0;
          n_nxt      = '0;
          cnt_nxt    = '0;
          pre_nxt    = 1'b1;
          hold_v_nxt = 1'b0;
          hold_nxt   = '{cnt: 5'd0, tag: in_tdata[47:32], tm: in_tdata[31:0],
                         kind: K_ADDED};
          unique case (in_tuser)
            OP_ADD: begin
              if (in_tdata[31:0] < cur_r) begin
                hold_nxt.kind = K_PAST;
                hold_v_nxt    = 1'b1;
                state_nxt     = S_FIN;
              end else if (occ_r == OCC_W'(QUEUE_DEPTH)) begin
                hold_nxt.kind = K_FULL;
                hold_v_nxt    = 1'b1;
                state_nxt     = S_FIN;
              end else begin
                i_nxt     = occ_r;
                state_nxt = S_ADRD;
              end
            end
            OP_ADVANCE: begin
              cur_nxt   = cur_r + in_tdata[31:0];
              state_nxt = S_SCRD;
            end
            OP_REMOVE, OP_LIST_AT, OP_LIST: state_nxt = S_SCRD;
            default: state_nxt = S_FIN;
          endcase
        end
      end

      // Wait for the read of entry i, or close the scan.
      S_SCRD: begin
        if (i_r == occ_r || (list_op && n_r == NUM_W'(MAX_RESULTS))) begin
          if (wr_op) begin
            occ_nxt = j_r;
          end
          if (op_r == OP_REMOVE) begin
            hold_nxt   = '{cnt: cnt_r, tag: 16'd0, tm: 32'd0, kind: K_REMOVED};
            hold_v_nxt = 1'b1;
          end
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SCPR;
        end
      end

      // Entry i is on the read port; emit, drop or compact it.
      S_SCPR: begin
        if (!(emit && hold_v_r && !out_free)) begin
          if (emit) begin
            if (hold_v_r) begin
              out_nxt   = hold_r;
              out_v_nxt = 1'b1;
              last_nxt  = 1'b0;
            end
            hold_nxt   = '{cnt: 5'd0, tag: rdata[47:32], tm: rd_tm,
                           kind: (op_r == OP_ADVANCE) ? K_FIRED : K_LISTED};
            hold_v_nxt = 1'b1;
            n_nxt      = n_r + NUM_W'(1);
          end
          if (drop) begin
            if (cnt_r != 5'd31) begin
              cnt_nxt = cnt_r + 5'd1;
            end
          end else begin
            pre_nxt = 1'b0;
            if (wr_op) begin
              we    = 1'b1;
              waddr = j_r[IDX_W-1:0];
              wdata = rdata;
              j_nxt = j_r + OCC_W'(1);
            end
          end
          i_nxt     = i_r + OCC_W'(1);
          state_nxt = S_SCRD;
        end
      end

      // Insert walk from the tail: slot i is free, look at slot i-1.
      S_ADRD: begin
        if (i_r == '0) begin
          we         = 1'b1;
          occ_nxt    = occ_r + OCC_W'(1);
          hold_v_nxt = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_ADCK;
        end
      end

      S_ADCK: begin
        we = 1'b1;
        if (rd_tm > tv_r) begin
          wdata     = rdata;
          i_nxt     = i_dec;
          state_nxt = S_ADRD;
        end else begin
          occ_nxt    = occ_r + OCC_W'(1);
          hold_v_nxt = 1'b1;
          state_nxt  = S_FIN;
        end
      end

      // Hand over the final result, or a none result.
      S_FIN: begin
        if (out_free) begin
          out_nxt    = hold_v_r ? hold_r
                                : '{cnt: 5'd0, tag: 16'd0, tm: 32'd0, kind: K_NONE};
          out_v_nxt  = 1'b1;
          last_nxt   = 1'b1;
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cur_r    <= '0;
      occ_r    <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      occ_r    <= occ_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    op_r   <= op_nxt;
    tv_r   <= tv_nxt;
    id_r   <= id_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    n_r    <= n_nxt;
    cnt_r  <= cnt_nxt;
    pre_r  <= pre_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'd0, out_r.cnt, out_r.tag, out_r.tm};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = last_r;

  // Checks on the sequencer.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCPR) |-> (j_r <= i_r && i_r < occ_r))
    else $error("compaction write index passed read index");

  a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCPR) |-> (n_r <= NUM_W'(MAX_RESULTS)))
    else $error("too many results in one operation");

  a_fin_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_tvalid && out_tlast && state_r == S_IDLE))
    else $error("final result not presented");

endmodule

// ----- tb/timed_event_queue_tb.sv -----
// Testbench for the timed event queue: drives operation words, predicts the
// result words from a local model of the sorted store, and checks each one.
// Depends on teq_pkg and the timed_event_queue RTL.
module timed_event_queue_tb
  import teq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] tm;
    logic [15:0] tag;
    logic [4:0]  cnt;
    logic        last;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // Local copy of the queue state.
  logic [31:0] q_times[$];
  logic [15:0] q_ids[$];
  logic [31:0] now_time;

  result_t     pending_results[$];
  int          fail_count;
  int          cycle_count;
  bit          hold_off;
  bit          quiet_mode;

  timed_event_queue u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Queue a result expectation.
  function automatic void push_result(logic [2:0] k, logic [31:0] t, logic [15:0] g,
                                      logic [4:0] c, logic l);
    result_t r;
    r.kind = k; r.tm = t; r.tag = g; r.cnt = c; r.last = l;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Predict the result words of one operation and update the local state.
  function automatic void predict_operation(logic [2:0] op, logic [31:0] tv, logic [15:0] id);
    int n;
    int pos;
    int cnt;
    int i;
    n = 0;
    case (op)
      OP_ADD: begin
        if (tv < now_time) push_result(K_PAST, tv, id, 5'd0, 1'b1);
        else if (q_times.size() >= QUEUE_DEPTH) push_result(K_FULL, tv, id, 5'd0, 1'b1);
        else begin
          pos = 0;
          while (pos < q_times.size() && q_times[pos] <= tv) pos++;
          q_times.insert(pos, tv);
          q_ids.insert(pos, id);
          push_result(K_ADDED, tv, id, 5'd0, 1'b1);
        end
        return;
      end
      OP_REMOVE: begin
        cnt = 0;
        i = 0;
        while (i < q_times.size()) begin
          if (q_times[i] == tv) begin
            q_times.delete(i); q_ids.delete(i); cnt++;
          end else i++;
        end
        if (cnt > 31) cnt = 31;
        push_result(K_REMOVED, 32'd0, 16'd0, cnt[4:0], 1'b1);
        return;
      end
      OP_ADVANCE: begin
        now_time = now_time + tv;
        while (n < MAX_RESULTS && q_times.size() > 0 && q_times[0] <= now_time) begin
          push_result(K_FIRED, q_times[0], q_ids[0], 5'd0, 1'b0);
          void'(q_times.pop_front());
          void'(q_ids.pop_front());
          n++;
        end
      end
      OP_LIST_AT: begin
        for (i = 0; i < q_times.size() && n < MAX_RESULTS; i++)
          if (q_times[i] == tv) begin
            push_result(K_LISTED, q_times[i], q_ids[i], 5'd0, 1'b0);
            n++;
          end
      end
      OP_LIST: begin
        for (i = 0; i < q_times.size() && n < MAX_RESULTS; i++) begin
          push_result(K_LISTED, q_times[i], q_ids[i], 5'd0, 1'b0);
          n++;
        end
      end
      default: ;
    endcase
    if (n == 0) push_result(K_NONE, 32'd0, 16'd0, 5'd0, 1'b1);
    else pending_results[$].last = 1'b1;
  endfunction

  // Offer one word at the next falling edge, with random idle gaps unless
  // quiet; returns at the rising edge that accepts it.
  task automatic send_word(logic [2:0] op, logic [31:0] tv, logic [15:0] id);
    @(negedge clk);
    while (!quiet_mode && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {8'd0, id, tv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_operation(op, tv, id);
  endtask

  // Result ready: random stalls, or a long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else out_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 29);
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h kind %0d last %b", out_tdata, out_tuser,
               out_tlast);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tuser !== exp_r.kind) begin
          $error("kind expected %0d actual %0d", exp_r.kind, out_tuser); fail_count++;
        end
        if (out_tdata[31:0] !== exp_r.tm) begin
          $error("event_time expected %0d actual %0d", exp_r.tm, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[47:32] !== exp_r.tag) begin
          $error("event_tag expected %0d actual %0d", exp_r.tag, out_tdata[47:32]);
          fail_count++;
        end
        if (out_tdata[52:48] !== exp_r.cnt) begin
          $error("removed_count expected %0d actual %0d", exp_r.cnt, out_tdata[52:48]);
          fail_count++;
        end
        if (out_tlast !== exp_r.last) begin
          $error("last expected %0d actual %0d", exp_r.last, out_tlast); fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] near_time();
    case ($urandom_range(3))
      0: return now_time + $urandom_range(40);
      1: return q_times.size() > 0 ? q_times[$urandom_range(q_times.size() - 1)] : now_time;
      2: return now_time - $urandom_range(5);
      default: return $urandom();
    endcase
  endfunction

  // Directed: extremes, every operation, past, a queue filled to depth, unknown codes.
  task automatic test_directed();
    int i;
    send_word(OP_LIST, 32'd0, 16'd0);
    send_word(OP_ADD, 32'd0, 16'hFFFF);
    send_word(OP_ADD, 32'hFFFF_FFFF, 16'h0000);
    send_word(OP_ADD, 32'd5, 16'h1234);
    send_word(OP_ADD, 32'd5, 16'h4321);
    send_word(OP_LIST_AT, 32'd5, 16'd0);
    send_word(OP_REMOVE, 32'd5, 16'd0);
    send_word(OP_REMOVE, 32'd99, 16'd0);
    send_word(3'd5, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(3'd6, 32'd1, 16'd1);
    send_word(3'd7, 32'd2, 16'd2);
    send_word(OP_ADVANCE, 32'd10, 16'hFFFF);
    send_word(OP_ADD, 32'd3, 16'hAAAA);
    for (i = 0; i < 15; i++) send_word(OP_ADD, 32'd20, i[15:0]);
    send_word(OP_LIST, 32'd0, 16'd0);
    send_word(OP_ADVANCE, 32'hFFFF_FFF0, 16'd0);
    send_word(OP_ADVANCE, 32'd0, 16'd0);
    send_word(OP_ADVANCE, 32'd30, 16'd0);
  endtask

  // Long receiver hold-off while the sender keeps offering words.
  task automatic test_backpressure();
    int i;
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (i = 0; i < 12; i++) send_word(OP_ADD, now_time + i, i[15:0]);
    join
    send_word(OP_LIST, 32'd0, 16'd0);
  endtask

  // Random mix weighted toward adds and near-present times.
  task automatic test_random(int count, bit quiet);
    int i;
    int pick;
    quiet_mode = quiet;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) send_word(OP_ADD, near_time(), 16'($urandom_range(16'hFFFF)));
      else if (pick < 58) send_word(OP_REMOVE, near_time(), 16'($urandom_range(16'hFFFF)));
      else if (pick < 75) send_word(OP_ADVANCE, $urandom_range(9) == 0 ? $urandom()
                                    : $urandom_range(30), 16'($urandom_range(16'hFFFF)));
      else if (pick < 86) send_word(OP_LIST_AT, near_time(),
                                    16'($urandom_range(16'hFFFF)));
      else if (pick < 96) send_word(OP_LIST, $urandom(), 16'($urandom_range(16'hFFFF)));
      else send_word(3'($urandom_range(7, 5)), $urandom(), 16'($urandom_range(16'hFFFF)));
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    now_time = '0; fail_count = 0; cycle_count = 0;
    hold_off = 1'b0; quiet_mode = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random(140, 1'b0);
    test_random(60, 1'b1);
    test_random(85, 1'b0);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
